// ===== src/sgc_pkg.sv =====
`timescale 1ns / 1ps

package sgc_pkg;

	// Fraction bits of the position t and of the eased fraction u
	localparam int FRAC_BITS = 16;

	localparam int SAMPLE_W = 32;
	localparam int DIFF_W   = SAMPLE_W + 1;
	localparam int T_W      = FRAC_BITS + 1;
	localparam int CHAN_W   = 8;
	localparam int COEF_W   = 9;
	localparam int ADDR_W   = 1;
	localparam int NUM_SEG  = 4;
	localparam int NUM_CHAN = 3;

	localparam logic [T_W-1:0] ONE = T_W'(1) << FRAC_BITS;

	// Register indexes
	localparam logic [ADDR_W-1:0] REG_RANGE_LOW  = 1'b0;
	localparam logic [ADDR_W-1:0] REG_RANGE_HIGH = 1'b1;

	localparam logic [SAMPLE_W-1:0] RANGE_LOW_RST  = 32'h0000_0000;
	localparam logic [SAMPLE_W-1:0] RANGE_HIGH_RST = 32'h0001_0000;

	// Color shown for an empty range
	localparam logic [CHAN_W-1:0] EMPTY_RED   = 8'd120;
	localparam logic [CHAN_W-1:0] EMPTY_GREEN = 8'd200;
	localparam logic [CHAN_W-1:0] EMPTY_BLUE  = 8'd255;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [1:0] seg_t;

	// Per segment (blue, cyan, green, yellow), per channel (red, green, blue)
	localparam coef_t GRAD_BASE [NUM_SEG][NUM_CHAN] = '{
		'{ 9'sd15,  9'sd30,  9'sd120},
		'{ 9'sd55,  9'sd150, 9'sd255},
		'{ 9'sd155, 9'sd230, 9'sd155},
		'{ 9'sd235, 9'sd255, 9'sd55 }
	};
	localparam coef_t GRAD_DELTA [NUM_SEG][NUM_CHAN] = '{
		'{ 9'sd40,  9'sd120,  9'sd135},
		'{ 9'sd100, 9'sd80,  -9'sd100},
		'{ 9'sd80,  9'sd25,  -9'sd100},
		'{ 9'sd20,  9'sd0,    9'sd50 }
	};

	// Item state inside the divider
	typedef struct packed {
		logic                 empty;
		logic                 sat;
		logic [DIFF_W-1:0]    rem;
		logic [FRAC_BITS-1:0] quo;
	} div_t;

	// Item state handed to the shading stages
	typedef struct packed {
		logic           empty;
		logic [T_W-1:0] t;
	} pos_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} rgb_t;

endpackage

// ===== src/sgc_div_stage.sv =====
`timescale 1ns / 1ps

module sgc_div_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  sgc_pkg::div_t              in_data,
	input  logic [sgc_pkg::DIFF_W-1:0] span,
	output logic                       out_valid,
	input  logic                       out_ready,
	output sgc_pkg::div_t              out_data
);

	logic [sgc_pkg::DIFF_W:0]   shifted;
	logic                       take;
	sgc_pkg::div_t              next_c;
	sgc_pkg::div_t              div_s1;
	logic                       valid_s1;

	// One restoring step: shift remainder, subtract span when it fits
	always_comb begin
		shifted = {in_data.rem, 1'b0};
		take    = shifted >= {1'b0, span};
		next_c  = in_data;
		if (take) begin
			next_c.rem = sgc_pkg::DIFF_W'(shifted - {1'b0, span});
		end else begin
			next_c.rem = shifted[sgc_pkg::DIFF_W-1:0];
		end
		next_c.quo = {in_data.quo[sgc_pkg::FRAC_BITS-2:0], take};
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			div_s1 <= next_c;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = div_s1;

endmodule

// ===== src/sgc_shade.sv =====
`timescale 1ns / 1ps

module sgc_shade (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sgc_pkg::pos_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output sgc_pkg::rgb_t  out_data
);

	localparam int F     = sgc_pkg::FRAC_BITS;
	localparam int T_W   = sgc_pkg::T_W;
	localparam int M_W   = T_W + 1;
	localparam int MUL_W = sgc_pkg::COEF_W + T_W + 1;
	localparam int ACC_W = MUL_W + 1;

	logic rdy1, rdy2, rdy3;

	// Stage 1: segment, local fraction, square
	sgc_pkg::seg_t      seg_c;
	logic [T_W-1:0]     f_c;
	logic [2*T_W-1:0]   sq_full_c;
	sgc_pkg::seg_t      seg_s1;
	logic [T_W-1:0]     f_s1;
	logic [T_W-1:0]     sq_s1;
	logic               empty_s1;
	logic               valid_s1;

	always_comb begin
		if (in_data.t[F]) begin
			seg_c = 2'd3;
			f_c   = sgc_pkg::ONE;
		end else begin
			seg_c = in_data.t[F-1:F-2];
			f_c   = {1'b0, in_data.t[F-3:0], 2'b00};
		end
		sq_full_c = (2*T_W)'(f_c) * (2*T_W)'(f_c);
	end

	// Stage 2: u = sq * (3 - 2f)
	logic [M_W-1:0]       m_c;
	logic [T_W+M_W-1:0]   u_full_c;
	sgc_pkg::seg_t        seg_s2;
	logic [T_W-1:0]       u_s2;
	logic                 empty_s2;
	logic                 valid_s2;

	always_comb begin
		m_c      = (M_W'(3) << F) - {f_s1, 1'b0};
		u_full_c = (T_W+M_W)'(sq_s1) * (T_W+M_W)'(m_c);
	end

	// Stage 3: base + delta * u per channel
	logic signed [MUL_W-1:0]       mul_c [sgc_pkg::NUM_CHAN];
	logic signed [ACC_W-1:0]       acc_c [sgc_pkg::NUM_CHAN];
	logic [sgc_pkg::CHAN_W-1:0]    chan_c [sgc_pkg::NUM_CHAN];
	sgc_pkg::rgb_t                 rgb_c;
	sgc_pkg::rgb_t                 rgb_s3;
	logic                          valid_s3;

	always_comb begin
		for (int k = 0; k < sgc_pkg::NUM_CHAN; k++) begin
			mul_c[k] = MUL_W'(sgc_pkg::GRAD_DELTA[seg_s2][k]) * MUL_W'($signed({1'b0, u_s2}));
			acc_c[k] = (ACC_W'(sgc_pkg::GRAD_BASE[seg_s2][k]) <<< F) + ACC_W'(mul_c[k]);
			chan_c[k] = acc_c[k][ACC_W-1] ? '0 : acc_c[k][F+sgc_pkg::CHAN_W-1:F];
		end
		if (empty_s2) begin
			rgb_c.red   = sgc_pkg::EMPTY_RED;
			rgb_c.green = sgc_pkg::EMPTY_GREEN;
			rgb_c.blue  = sgc_pkg::EMPTY_BLUE;
		end else begin
			rgb_c.red   = chan_c[0];
			rgb_c.green = chan_c[1];
			rgb_c.blue  = chan_c[2];
		end
	end

	assign rdy3     = !valid_s3 || out_ready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= in_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			seg_s1   <= seg_c;
			f_s1     <= f_c;
			sq_s1    <= sq_full_c[2*F:F];
			empty_s1 <= in_data.empty;
		end
		if (rdy2 && valid_s1) begin
			seg_s2   <= seg_s1;
			u_s2     <= u_full_c[2*F:F];
			empty_s2 <= empty_s1;
		end
		if (rdy3 && valid_s2) begin
			rgb_s3 <= rgb_c;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = rgb_s3;

`ifndef SYNTHESIS
	a_sq_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (sq_s1 <= sgc_pkg::ONE))
		else $error("square above one");

	a_u_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (u_s2 <= sgc_pkg::ONE))
		else $error("eased fraction above one");

	// Hold a stalled color unchanged until the receiver takes it
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled color changed or dropped");
`endif

endmodule

// ===== src/scalar_to_color_gradient_top.sv =====
`timescale 1ns / 1ps

// Scalar to color gradient: maps a signed Q16.16 sample to an RGB color.
//
// Input stream (s_*): one sample per transfer in s_tdata[31:0].
// Output stream (m_*): one color per transfer, red in m_tdata[7:0],
// green in [15:8], blue in [23:16].
// Write port (wr_*): register 0 is range_low, register 1 is range_high,
// both signed Q16.16. Write only while no sample is in flight.
//
// An input transfer reaches m_tvalid through one input register, one
// range-compare stage, 16 divider stages (one quotient bit each), then
// square, ease and channel stages. Throughput is one sample per cycle
// while m_tready is high. Every stage has its own valid bit and
// local ready, so a stall on m_tready holds results in place and bubbles
// still fill; s_tready drops only when all 21 stages are occupied.
// Reset clears all valid bits and loads range_low = 0, range_high = 1.0.
// An empty range (high <= low) gives the color 120, 200, 255.
module scalar_to_color_gradient_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [31:0]                  s_tdata,   // [31:0] sample
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
	input  logic                         wr_en,
	input  logic [sgc_pkg::ADDR_W-1:0]   wr_addr,
	input  logic [31:0]                  wr_data
);

	localparam int F      = sgc_pkg::FRAC_BITS;
	localparam int DIFF_W = sgc_pkg::DIFF_W;

	// Range registers
	logic [sgc_pkg::SAMPLE_W-1:0] range_low_q;
	logic [sgc_pkg::SAMPLE_W-1:0] range_high_q;
	logic [DIFF_W-1:0]            span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= sgc_pkg::RANGE_LOW_RST;
			range_high_q <= sgc_pkg::RANGE_HIGH_RST;
		end else if (wr_en) begin
			case (wr_addr)
				sgc_pkg::REG_RANGE_LOW: begin
					range_low_q <= wr_data;
				end
				sgc_pkg::REG_RANGE_HIGH: begin
					range_high_q <= wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Span as a 33-bit value; positive whenever the range is not empty
	logic [DIFF_W-1:0] span_c;
	logic              empty_c;

	assign span_c  = {range_high_q[31], range_high_q} - {range_low_q[31], range_low_q};
	assign empty_c = $signed(range_high_q) <= $signed(range_low_q);

	// Registered copy for the divider stages; items reach them only after
	// the input and stage 2 registers, so the copy has settled by then
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= DIFF_W'(sgc_pkg::RANGE_HIGH_RST);
		end else begin
			span_q <= span_c;
		end
	end

	// Stage 1: input register
	logic [sgc_pkg::SAMPLE_W-1:0] sample_s1;
	logic                         valid_s1;
	logic                         rdy1;
	logic                         rdy2;

	assign rdy1     = !valid_s1 || rdy2;
	assign s_tready = rdy1;

	// Stage 2: offset from range_low, clamp decisions, divider seed
	logic [DIFF_W-1:0] diff_c;
	logic              nonpos_c;
	logic              sat_c;
	sgc_pkg::div_t     seed_c;
	sgc_pkg::div_t     div_s2;
	logic              valid_s2;

	always_comb begin
		diff_c   = {sample_s1[31], sample_s1} - {range_low_q[31], range_low_q};
		nonpos_c = diff_c[DIFF_W-1] || (diff_c == '0);
		sat_c    = !nonpos_c && (diff_c >= span_c);
		seed_c.empty = empty_c;
		seed_c.sat   = sat_c;
		seed_c.quo   = '0;
		// Zero remainder yields a zero quotient: covers at-or-below range_low
		if (empty_c || nonpos_c || sat_c) begin
			seed_c.rem = '0;
		end else begin
			seed_c.rem = diff_c;
		end
	end

	// Divider chain: one quotient bit per stage
	sgc_pkg::div_t div_pipe [F+1];
	logic          div_vld  [F+1];
	logic          div_rdy  [F+1];

	assign rdy2       = !valid_s2 || div_rdy[0];
	assign div_vld[0] = valid_s2;
	assign div_pipe[0] = div_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= s_tvalid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			sample_s1 <= s_tdata;
		end
		if (rdy2 && valid_s1) begin
			div_s2 <= seed_c;
		end
	end

	for (genvar i = 0; i < F; i++) begin : g_div
		sgc_div_stage u_div_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_vld[i]),
			.in_ready  (div_rdy[i]),
			.in_data   (div_pipe[i]),
			.span      (span_q),
			.out_valid (div_vld[i+1]),
			.out_ready (div_rdy[i+1]),
			.out_data  (div_pipe[i+1])
		);
	end

	// Position t: saturate to one at or above range_high
	sgc_pkg::pos_t pos_c;

	always_comb begin
		pos_c.empty = div_pipe[F].empty;
		if (div_pipe[F].sat) begin
			pos_c.t = sgc_pkg::ONE;
		end else begin
			pos_c.t = {1'b0, div_pipe[F].quo};
		end
	end

	sgc_pkg::rgb_t rgb;

	sgc_shade u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_vld[F]),
		.in_ready  (div_rdy[F]),
		.in_data   (pos_c),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (rgb)
	);

	assign m_tdata = rgb;

`ifndef SYNTHESIS
	// An empty output register frees every stage upstream
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_entry_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted sample lost at entry");

	a_stage2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !div_rdy[0]) |=> valid_s2)
		else $error("stalled item dropped at stage 2");
`endif

endmodule
